// ===== rtl/bdhr_pkg.sv =====
// Package with shared types and constants for the button debounce, hold and repeat block.
`timescale 1ns / 1ps
`default_nettype none

package bdhr_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned DelayWidth = 16;
   localparam int unsigned EventWidth = 2;
   localparam int unsigned CsrAddrWidth = 2;

   localparam logic [EventWidth-1:0] EV_NONE    = 2'd0;
   localparam logic [EventWidth-1:0] EV_PRESS   = 2'd1;
   localparam logic [EventWidth-1:0] EV_RELEASE = 2'd2;
   localparam logic [EventWidth-1:0] EV_HOLD    = 2'd3;

   localparam logic [CsrAddrWidth-1:0] CSR_ACTIVE_LOW     = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_DEBOUNCE_DELAY = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_LONG_HOLD_TIME = 2'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_RAPID_PERIOD   = 2'd3;

   localparam logic [DelayWidth-1:0] DEBOUNCE_DELAY_RST = 16'd50;
   localparam logic [DelayWidth-1:0] LONG_HOLD_TIME_RST = 16'd500;
   localparam logic [DelayWidth-1:0] RAPID_PERIOD_RST   = 16'd100;

   typedef struct packed {
      logic                  active_low;
      logic [DelayWidth-1:0] debounce_delay;
      logic [DelayWidth-1:0] long_hold_time;
      logic [DelayWidth-1:0] rapid_period;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/button_debounce_hold_repeat.sv =====
// Top level of the button debouncer with hold and auto-repeat events.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_tvalid/tready    tdata = pin_level, now_ms
//   rsp      out        rsp_tvalid/tready    tdata = event_res
//   csr      in         csr_valid/ready      csr_addr, csr_data
//
// A sample is registered on transfer and decided into the result register once that
// register is free, and the result is offered from there.
// One sample is taken every cycle while req_tready is high; the state update is a single pass of subtracts
// and compares on the sample register.
// Synchronous reset restores the register defaults and clears all pin state.
// A stalled result holds both stages; req_tready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_hold_repeat
   import bdhr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [39:0]             req_tdata,  // [0] pin_level, [32:1] now_ms, rest zero
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [7:0]                   rsp_tdata,  // [1:0] event_res, rest zero
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CsrAddrWidth-1:0] csr_addr,
   input  wire logic [DelayWidth-1:0]   csr_data
);

   cfg_type cfg;

   logic                  smp_vld_ff;
   logic                  smp_level_ff;
   logic [TimeWidth-1:0]  smp_time_ff;
   logic                  out_vld_ff;
   logic [EventWidth-1:0] out_event_ff;
   logic [EventWidth-1:0] event_in;
   logic                  out_free;
   logic                  step;
   logic                  req_xfer;

   assign csr_ready = 1'b1;

   bdhr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_addr  (csr_addr),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign out_free   = !out_vld_ff || rsp_tready;
   assign step       = smp_vld_ff && out_free;
   assign req_tready = !smp_vld_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   bdhr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .pin_level (smp_level_ff),
      .now_ms    (smp_time_ff),
      .cfg       (cfg),
      .event_res (event_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            smp_vld_ff <= req_tvalid;
         end
         if (out_free) begin
            out_vld_ff <= smp_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         smp_level_ff <= req_tdata[0];
         smp_time_ff  <= req_tdata[TimeWidth:1];
      end
      if (step) begin
         out_event_ff <= event_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(8-EventWidth){1'b0}}, out_event_ff};

endmodule

`default_nettype wire

// ===== rtl/bdhr_csr.sv =====
// Configuration register file of the button debounce, hold and repeat block.
`timescale 1ns / 1ps
`default_nettype none

module bdhr_csr
   import bdhr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_valid,
   input  wire logic [CsrAddrWidth-1:0] csr_addr,
   input  wire logic [DelayWidth-1:0]   csr_data,
   output cfg_type                      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_addr)
            CSR_ACTIVE_LOW:     cfg_in.active_low     = csr_data[0];
            CSR_DEBOUNCE_DELAY: cfg_in.debounce_delay = csr_data;
            CSR_LONG_HOLD_TIME: cfg_in.long_hold_time = csr_data;
            CSR_RAPID_PERIOD:   cfg_in.rapid_period   = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low     <= 1'b1;
         cfg_ff.debounce_delay <= DEBOUNCE_DELAY_RST;
         cfg_ff.long_hold_time <= LONG_HOLD_TIME_RST;
         cfg_ff.rapid_period   <= RAPID_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/bdhr_core.sv =====
// Debounce, hold and repeat state with the event decision for one pin sample.
`timescale 1ns / 1ps
`default_nettype none

module bdhr_core
   import bdhr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic                  pin_level,
   input  wire logic [TimeWidth-1:0]  now_ms,
   input  cfg_type                    cfg,
   output logic      [EventWidth-1:0] event_res
);

   logic                 debounced_ff, debounced_in;
   logic                 last_raw_ff, last_raw_in;
   logic [TimeWidth-1:0] debounce_start_ff, debounce_start_in;
   logic [TimeWidth-1:0] hold_start_ff, hold_start_in;
   logic                 rapid_mode_ff, rapid_mode_in;

   logic                  pressed;
   logic [DelayWidth-1:0] interval;
   logic [TimeWidth-1:0]  start_eff;
   logic [TimeWidth-1:0]  hold_age;
   logic [TimeWidth-1:0]  stable_age;
   logic                  hold_fire;

   always_comb begin
      pressed    = pin_level ^ cfg.active_low;
      interval   = rapid_mode_ff ? cfg.rapid_period : cfg.long_hold_time;
      start_eff  = (pressed != last_raw_ff) ? now_ms : debounce_start_ff;
      hold_age   = now_ms - hold_start_ff;
      stable_age = now_ms - start_eff;
      hold_fire  = pressed && (hold_start_ff != '0) &&
                   (hold_age >= {{(TimeWidth-DelayWidth){1'b0}}, interval});

      debounced_in      = debounced_ff;
      last_raw_in       = last_raw_ff;
      debounce_start_in = start_eff;
      hold_start_in     = hold_start_ff;
      rapid_mode_in     = rapid_mode_ff;
      event_res         = EV_NONE;

      if (hold_fire) begin
         hold_start_in = now_ms;
         rapid_mode_in = 1'b1;
         event_res     = EV_HOLD;
      end else begin
         last_raw_in = pressed;
         if ((stable_age > {{(TimeWidth-DelayWidth){1'b0}}, cfg.debounce_delay}) &&
             (pressed != debounced_ff)) begin
            debounced_in = pressed;
            if (pressed) begin
               event_res     = EV_PRESS;
               hold_start_in = now_ms;
               rapid_mode_in = 1'b0;
            end else begin
               event_res     = EV_RELEASE;
               hold_start_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounced_ff      <= 1'b0;
         last_raw_ff       <= 1'b0;
         debounce_start_ff <= '0;
         hold_start_ff     <= '0;
         rapid_mode_ff     <= 1'b0;
      end else if (step) begin
         debounced_ff      <= debounced_in;
         last_raw_ff       <= last_raw_in;
         debounce_start_ff <= debounce_start_in;
         hold_start_ff     <= hold_start_in;
         rapid_mode_ff     <= rapid_mode_in;
      end
   end

   a_hold_sets_rapid : assert property (@(posedge clock) disable iff (reset)
      step && (event_res == EV_HOLD) |=> rapid_mode_ff)
      else $error("hold event did not switch to the rapid interval");

   a_release_disarms : assert property (@(posedge clock) disable iff (reset)
      step && (event_res == EV_RELEASE) |=> (hold_start_ff == '0) && !debounced_ff)
      else $error("release did not disarm the hold");

   a_press_latches : assert property (@(posedge clock) disable iff (reset)
      step && (event_res == EV_PRESS) |=> debounced_ff && !rapid_mode_ff)
      else $error("press did not update the debounced state");

   a_idle_holds : assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(hold_start_ff) && $stable(debounced_ff))
      else $error("state changed without a sample");

endmodule

`default_nettype wire
